// ===== rtl/core/rlsu_pkg.sv =====
// Shared types, constants and helpers for the RS-485 chain link supervisor.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rlsu_pkg;

    // Sizes fixed by the frame format and the register map
    localparam int MAX_BOARDS_DEF = 16;
    localparam int BOARD_W        = 4;
    localparam int BP_W           = 5;
    localparam int CLR_W          = 10;
    localparam int LIM_W          = 8;
    localparam int QUIET_W        = 11;
    localparam int MAP_W          = 64;
    localparam int FRAME_W        = 32;
    localparam int BITS_W         = 16;
    localparam int MISS_W         = 32;
    localparam int OP_W           = 2;
    localparam int CFG_AW         = 5;
    localparam int CFG_DW         = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_RX  = 2'd0;
    localparam logic [OP_W-1:0] OP_EOC = 2'd1;
    localparam logic [OP_W-1:0] OP_TX  = 2'd2;

    // Register indexes (byte address 8*index)
    localparam logic [1:0] REG_CLR = 2'd0;
    localparam logic [1:0] REG_LIM = 2'd1;
    localparam logic [1:0] REG_BP  = 2'd2;
    localparam logic [1:0] REG_MAP = 2'd3;

    // Register reset values
    localparam logic [CLR_W-1:0] CLR_RST = 10'd10;
    localparam logic [LIM_W-1:0] LIM_RST = 8'd5;
    localparam logic [BP_W-1:0]  BP_RST  = 5'd1;

    // Frame format codes
    localparam logic [2:0] RX_TYPE = 3'd2;
    localparam logic [2:0] TX_TYPE = 3'd3;
    localparam logic [3:0] TRAILER = 4'h3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RX,
        ST_TX,
        ST_COUNT,
        ST_GLOBAL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [CLR_W-1:0] clear_after_good;
        logic [LIM_W-1:0] errors_to_fault;
        logic [BP_W-1:0]  boards_present;
        logic [MAP_W-1:0] board_address_map;
    } cfg_t;

    typedef struct packed {
        logic [BOARD_W-1:0] board_index;
        logic               frame_ok;
        logic               board_matched;
        logic [BITS_W-1:0]  input_bits;
        logic               board_comm_error;
        logic               board_perm_error;
        logic [MISS_W-1:0]  invalid_count;
        logic               any_comm_error;
        logic               any_perm_error;
        logic [FRAME_W-1:0] tx_frame;
        logic               last;
    } result_t;

    // Sequencer commands to the datapath
    typedef struct packed {
        logic load_in;
        logic rx;
        logic tx;
        logic count;
        logic glob;
        logic emit;
    } cmd_t;

    // Datapath status back to the sequencer
    typedef struct packed {
        logic slot_free;
        logic last_board;
        logic no_boards;
    } sts_t;

    // XOR of the eight nibbles of a frame
    function automatic logic [3:0] nibble_xor(input logic [FRAME_W-1:0] w);
        logic [3:0] x;
        x = 4'h0;
        for (int i = 0; i < FRAME_W / 4; i++) begin
            x = x ^ w[4*i +: 4];
        end
        return x;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rlsu_if.sv =====
// Request and result channel interfaces of the link supervisor.
// Depends on rlsu_pkg for the field widths.
`default_nettype none

interface rlsu_in_if;
    import rlsu_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [FRAME_W-1:0]   frame_word;
    logic [BOARD_W-1:0]   board_select;
    logic [BITS_W-1:0]    output_bits;
    logic                 reset_request;

    modport source (
        output valid, operation, frame_word, board_select, output_bits, reset_request,
        input  ready
    );
    modport sink (
        input  valid, operation, frame_word, board_select, output_bits, reset_request,
        output ready
    );
endinterface

interface rlsu_out_if;
    import rlsu_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BOARD_W-1:0]   board_index;
    logic                 frame_ok;
    logic                 board_matched;
    logic [BITS_W-1:0]    input_bits;
    logic                 board_comm_error;
    logic                 board_perm_error;
    logic [MISS_W-1:0]    invalid_count;
    logic                 any_comm_error;
    logic                 any_perm_error;
    logic [FRAME_W-1:0]   tx_frame;
    logic                 last;

    modport source (
        output valid, board_index, frame_ok, board_matched, input_bits,
               board_comm_error, board_perm_error, invalid_count,
               any_comm_error, any_perm_error, tx_frame, last,
        input  ready
    );
    modport sink (
        input  valid, board_index, frame_ok, board_matched, input_bits,
               board_comm_error, board_perm_error, invalid_count,
               any_comm_error, any_perm_error, tx_frame, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/rlsu_cfg.sv =====
// APB-style configuration registers of the link supervisor.
// Depends on rlsu_pkg; registers at byte address 8*index, 64-bit data.
`default_nettype none

module rlsu_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rlsu_pkg::CFG_AW-1:0] paddr,
    input  logic [rlsu_pkg::CFG_DW-1:0] pwdata,
    output logic [rlsu_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    output rlsu_pkg::cfg_t              cfg
);
    import rlsu_pkg::*;

    logic [CLR_W-1:0] clr_reg;
    logic [LIM_W-1:0] lim_reg;
    logic [BP_W-1:0]  bp_reg;
    logic [MAP_W-1:0] map_reg;
    logic             wr_en;
    logic [1:0]       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[4:3];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= CLR_RST;
            lim_reg <= LIM_RST;
            bp_reg  <= BP_RST;
            map_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_CLR: clr_reg <= pwdata[CLR_W-1:0];
                REG_LIM: lim_reg <= pwdata[LIM_W-1:0];
                REG_BP:  bp_reg  <= pwdata[BP_W-1:0];
                REG_MAP: map_reg <= pwdata[MAP_W-1:0];
            endcase
        end
    end

    // read-back
    always_comb
    begin
        unique case (reg_sel)
            REG_CLR: prdata = CFG_DW'(clr_reg);
            REG_LIM: prdata = CFG_DW'(lim_reg);
            REG_BP:  prdata = CFG_DW'(bp_reg);
            REG_MAP: prdata = CFG_DW'(map_reg);
        endcase
    end

    assign cfg.clear_after_good  = clr_reg;
    assign cfg.errors_to_fault   = lim_reg;
    assign cfg.boards_present    = bp_reg;
    assign cfg.board_address_map = map_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rlsu_ctrl.sv =====
// Sequencer of the link supervisor: request acceptance and the board walks.
// Depends on rlsu_pkg; drives rlsu_dp through cmd_t and a board index.
`default_nettype none

module rlsu_ctrl #(
    parameter int MAX_CHAIN_BOARDS = rlsu_pkg::MAX_BOARDS_DEF,
    parameter int IDX_W            = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [rlsu_pkg::OP_W-1:0] in_op,
    output logic                      in_ready,
    output rlsu_pkg::cmd_t            cmd,
    output logic [IDX_W-1:0]          idx,
    input  rlsu_pkg::sts_t            sts
);
    import rlsu_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority case (in_op)
                        OP_RX:   state_next = ST_RX;
                        OP_TX:   state_next = ST_TX;
                        OP_EOC:  state_next = sts.no_boards ? ST_GLOBAL : ST_COUNT;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RX, ST_TX:
            begin
                if (sts.slot_free)
                    state_next = ST_IDLE;
            end
            ST_COUNT:
            begin
                if (sts.last_board)
                    state_next = ST_GLOBAL;
            end
            ST_GLOBAL:
            begin
                state_next = sts.no_boards ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.slot_free && sts.last_board)
                    state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        cmd.load_in = (state_reg == ST_IDLE) && in_valid;
        cmd.rx      = (state_reg == ST_RX) && sts.slot_free;
        cmd.tx      = (state_reg == ST_TX) && sts.slot_free;
        cmd.count   = (state_reg == ST_COUNT);
        cmd.glob    = (state_reg == ST_GLOBAL);
        cmd.emit    = (state_reg == ST_EMIT) && sts.slot_free;
    end

    // board walk counter, shared by the update and report passes
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load_in || cmd.glob)
            idx_next = '0;
        else if (cmd.count || cmd.emit)
            idx_next = sts.last_board ? '0 : idx_reg + IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign idx = idx_reg;

`ifndef ASSERT_OFF
    a_count_to_global: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COUNT && sts.last_board) |=> (state_reg == ST_GLOBAL))
        else $error("update pass did not end in global step");
    a_empty_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_op == OP_EOC && sts.no_boards)
        |=> (state_reg == ST_GLOBAL))
        else $error("empty chain end of cycle skipped global step");
    a_report_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GLOBAL) |=> (idx_reg == '0))
        else $error("report pass does not start at board zero");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rlsu_dp.sv =====
// Datapath of the link supervisor: per-board state, frame checks and builds,
// board update logic and the result register. Depends on rlsu_pkg.
`default_nettype none

module rlsu_dp #(
    parameter int MAX_CHAIN_BOARDS = rlsu_pkg::MAX_BOARDS_DEF,
    parameter int IDX_W            = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rlsu_pkg::cfg_t               cfg,
    input  rlsu_pkg::cmd_t               cmd,
    input  logic [IDX_W-1:0]             idx,
    input  logic [rlsu_pkg::FRAME_W-1:0] in_frame,
    input  logic [rlsu_pkg::BOARD_W-1:0] in_sel,
    input  logic [rlsu_pkg::BITS_W-1:0]  in_obits,
    input  logic                         in_rr,
    input  logic                         out_ready,
    output logic                         out_valid,
    output rlsu_pkg::result_t            result,
    output rlsu_pkg::sts_t               sts
);
    import rlsu_pkg::*;

    localparam int NB = MAX_CHAIN_BOARDS;

    // latched request
    logic [FRAME_W-1:0] frame_reg;
    logic [BOARD_W-1:0] sel_reg;
    logic [BITS_W-1:0]  obits_reg;
    logic               rr_reg;

    // per-board state
    logic [NB-1:0]      rx_valid_reg;
    logic [BITS_W-1:0]  rx_bits_reg [NB];
    logic [QUIET_W-1:0] quiet_reg   [NB];
    logic [LIM_W-1:0]   err_reg     [NB];
    logic [NB-1:0]      comm_reg;
    logic [NB-1:0]      perm_reg;
    logic [MISS_W-1:0]  miss_reg    [NB];
    logic               gcomm_reg;
    logic               gperm_reg;
    logic               any_reg;

    // result slot
    result_t            res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    logic               load_res;

    logic [BP_W-1:0]    n_boards;
    logic               clear_perm;

    // boards in use, capped at the chain size
    assign n_boards = (cfg.boards_present > BP_W'(NB)) ? BP_W'(NB) : cfg.boards_present;
    assign clear_perm = rr_reg & ~gcomm_reg;

    assign sts.slot_free  = ~out_valid_reg | out_ready;
    assign sts.last_board = ((BP_W'(idx) + BP_W'(1)) == n_boards);
    assign sts.no_boards  = (n_boards == '0);

    // receive: frame checks and address match, lowest board wins
    logic [7:0]       rx_b0;
    logic             rx_ok;
    logic [4:0]       rx_addr;
    logic             hit_any;
    logic [IDX_W-1:0] hit_idx;

    assign rx_b0   = frame_reg[31:24];
    assign rx_addr = rx_b0[7:3];
    assign rx_ok   = (nibble_xor(frame_reg) == 4'h0) && (rx_b0[2:0] == RX_TYPE)
                     && (frame_reg[3:0] == TRAILER);

    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = NB - 1; i >= 0; i--)
        begin
            if ((BP_W'(i) < n_boards)
                && (rx_addr == {1'b0, cfg.board_address_map[4*i +: 4]}))
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    // transmit: frame build with nibble checksum
    logic [3:0]         tx_addr;
    logic [FRAME_W-1:0] tx_base;
    logic [FRAME_W-1:0] tx_word;

    assign tx_addr = cfg.board_address_map[4*sel_reg +: 4];
    assign tx_base = {1'b0, tx_addr, TX_TYPE, obits_reg, 4'h0, TRAILER};
    assign tx_word = tx_base | {24'h0, nibble_xor(tx_base), 4'h0};

    // board update at the walk index
    logic [QUIET_W-1:0] q_cur, q_mid, q_new;
    logic [LIM_W:0]     e_mid;
    logic [LIM_W-1:0]   e_new;
    logic               c_mid, c_new, p_new, fault;
    logic [MISS_W-1:0]  m_new;

    always_comb
    begin
        q_cur = quiet_reg[idx];
        q_mid = q_cur;
        e_mid = {1'b0, err_reg[idx]};
        c_mid = comm_reg[idx];
        m_new = miss_reg[idx];
        if (rx_valid_reg[idx])
        begin
            // enough quiet cycles: clear the board's errors
            if (q_cur >= {1'b0, cfg.clear_after_good})
            begin
                q_mid = {1'b0, cfg.clear_after_good};
                e_mid = '0;
                c_mid = 1'b0;
            end
        end
        else
        begin
            e_mid = {1'b0, err_reg[idx]} + (LIM_W+1)'(1);
            q_mid = '0;
            m_new = miss_reg[idx] + MISS_W'(1);
        end
        fault = (e_mid >= {1'b0, cfg.errors_to_fault});
        e_new = fault ? cfg.errors_to_fault : e_mid[LIM_W-1:0];
        c_new = fault | c_mid;
        p_new = ~clear_perm & (perm_reg[idx] | fault);
        q_new = q_mid + QUIET_W'(1);
    end

    // result selection
    assign load_res = cmd.rx | cmd.tx | cmd.emit;

    always_comb
    begin
        res_next                = '0;
        res_next.any_comm_error = gcomm_reg;
        res_next.any_perm_error = gperm_reg;
        res_next.last           = 1'b1;
        priority if (cmd.rx)
        begin
            res_next.frame_ok      = rx_ok;
            res_next.board_matched = rx_ok & hit_any;
            res_next.board_index   = (rx_ok & hit_any) ? BOARD_W'(hit_idx) : '0;
            res_next.input_bits    = rx_ok ? frame_reg[23:8] : '0;
        end
        else if (cmd.tx)
        begin
            res_next.board_index = sel_reg;
            res_next.tx_frame    = tx_word;
        end
        else
        begin
            res_next.board_index      = BOARD_W'(idx);
            res_next.input_bits       = gperm_reg ? '0 : rx_bits_reg[idx];
            res_next.board_comm_error = comm_reg[idx];
            res_next.board_perm_error = perm_reg[idx];
            res_next.invalid_count    = miss_reg[idx];
            res_next.last             = sts.last_board;
        end
    end

    assign out_valid_next = load_res | (out_valid_reg & ~out_ready);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid_reg  <= '0;
            comm_reg      <= '0;
            perm_reg      <= '0;
            gcomm_reg     <= 1'b0;
            gperm_reg     <= 1'b0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NB; i++)
            begin
                rx_bits_reg[i] <= '0;
                quiet_reg[i]   <= '0;
                err_reg[i]     <= '0;
                miss_reg[i]    <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.load_in)
                any_reg <= 1'b0;
            // store a matched board's bits
            if (cmd.rx && rx_ok && hit_any)
            begin
                rx_bits_reg[hit_idx]  <= frame_reg[23:8];
                rx_valid_reg[hit_idx] <= 1'b1;
            end
            // update pass
            if (cmd.count)
            begin
                quiet_reg[idx] <= q_new;
                err_reg[idx]   <= e_new;
                comm_reg[idx]  <= c_new;
                perm_reg[idx]  <= p_new;
                miss_reg[idx]  <= m_new;
                any_reg        <= any_reg | c_new;
            end
            // global flags, valid marks dropped
            if (cmd.glob)
            begin
                gcomm_reg    <= any_reg;
                gperm_reg    <= (gperm_reg & ~clear_perm) | any_reg;
                rx_valid_reg <= '0;
            end
            // report pass clears input bits under global permanent error
            if (cmd.emit && gperm_reg)
                rx_bits_reg[idx] <= '0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            frame_reg <= in_frame;
            sel_reg   <= in_sel;
            obits_reg <= in_obits;
            rr_reg    <= in_rr;
        end
        if (load_res)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

`ifndef ASSERT_OFF
    a_marks_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.glob |=> (rx_valid_reg == '0))
        else $error("valid marks survived end of cycle");
    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.last_board) |=> (out_valid_reg && res_reg.last))
        else $error("final board report not marked last");
    a_perm_follows_comm: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.glob && any_reg) |=> (gcomm_reg && gperm_reg))
        else $error("global flags not set by board comm error");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rs485_io_frame_link_supervisor_unit.sv =====
// Top level of the RS-485 chain link supervisor: configuration registers,
// sequencer and datapath. Depends on rlsu_pkg, rlsu_if, rlsu_cfg, rlsu_ctrl, rlsu_dp.
//
//   channel   direction  handshake        carries
//   in_ch     sink       valid / ready    operation, frame, board select, outputs
//   out_ch    source     valid / ready    one board report or frame result
//   apb       slave      psel / penable   four registers at byte address 8*index
//
// Receive and transmit: result loaded in state RX or TX once the output slot is free.
// End of cycle: the single board update path is walked once to update counters,
// then the global step, then once more to report; an empty chain skips both walks.
// Reset clears all board state at once; no clearing pass.
// A waiting result sits in the output register; the next request is taken
// once the current one's results are all loaded.
`default_nettype none

module rs485_io_frame_link_supervisor_unit #(
    parameter int MAX_CHAIN_BOARDS = rlsu_pkg::MAX_BOARDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rlsu_pkg::CFG_AW-1:0] paddr,
    input  logic [rlsu_pkg::CFG_DW-1:0] pwdata,
    output logic [rlsu_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    rlsu_in_if.sink                     in_ch,
    rlsu_out_if.source                  out_ch
);
    import rlsu_pkg::*;

    localparam int IDX_W = (MAX_CHAIN_BOARDS > 1) ? $clog2(MAX_CHAIN_BOARDS) : 1;

    cfg_t             cfg;
    cmd_t             cmd;
    sts_t             sts;
    logic [IDX_W-1:0] idx;
    result_t          result;

    rlsu_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rlsu_ctrl #(
        .MAX_CHAIN_BOARDS (MAX_CHAIN_BOARDS),
        .IDX_W            (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_op    (in_ch.operation),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .idx      (idx),
        .sts      (sts)
    );

    rlsu_dp #(
        .MAX_CHAIN_BOARDS (MAX_CHAIN_BOARDS),
        .IDX_W            (IDX_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .idx       (idx),
        .in_frame  (in_ch.frame_word),
        .in_sel    (in_ch.board_select),
        .in_obits  (in_ch.output_bits),
        .in_rr     (in_ch.reset_request),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .result    (result),
        .sts       (sts)
    );

    // result fields onto the channel
    assign out_ch.board_index      = result.board_index;
    assign out_ch.frame_ok         = result.frame_ok;
    assign out_ch.board_matched    = result.board_matched;
    assign out_ch.input_bits       = result.input_bits;
    assign out_ch.board_comm_error = result.board_comm_error;
    assign out_ch.board_perm_error = result.board_perm_error;
    assign out_ch.invalid_count    = result.invalid_count;
    assign out_ch.any_comm_error   = result.any_comm_error;
    assign out_ch.any_perm_error   = result.any_perm_error;
    assign out_ch.tx_frame         = result.tx_frame;
    assign out_ch.last             = result.last;

endmodule

`default_nettype wire

// ===== test/rs485_io_frame_link_supervisor_unit_tb.sv =====
// Self-checking testbench for the RS-485 chain link supervisor: a scoreboard class
// predicts every board report and frame result, plain tasks drive requests and registers.
// Depends on rlsu_pkg, rlsu_if and the rs485_io_frame_link_supervisor_unit RTL.
`default_nettype none

module rs485_io_frame_link_supervisor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlsu_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
    localparam int unsigned     LIMIT      = 400000;
    localparam int unsigned     HOLD_OFF   = 300;
    localparam int unsigned     SETTLE     = 48;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [FRAME_W-1:0] frame_word;
        logic [BOARD_W-1:0] board_select;
        logic [BITS_W-1:0]  output_bits;
        logic               reset_request;
    } request_t;

    // Frame checksum: fold the word down to one nibble
    function automatic logic [3:0] fold_nibbles(input logic [31:0] w);
        logic [15:0] h;
        logic [7:0]  b;
        h = w[31:16] ^ w[15:0];
        b = h[15:8] ^ h[7:0];
        return b[7:4] ^ b[3:0];
    endfunction

    // Board state tracker and report checker
    class link_scoreboard;
        logic [CLR_W-1:0] clr_cfg;
        logic [LIM_W-1:0] lim_cfg;
        logic [BP_W-1:0]  bp_cfg;
        logic [MAP_W-1:0] addr_map;

        bit               rx_seen[16];
        logic [15:0]      latched_bits[16];
        int unsigned      quiet[16];
        int unsigned      err_cnt[16];
        bit               comm[16];
        bit               perm[16];
        logic [31:0]      missed[16];
        bit               any_comm;
        bit               any_perm;

        result_t          pending[$];
        int unsigned      failures;

        function new();
            clr_cfg  = CLR_RST;
            lim_cfg  = LIM_RST;
            bp_cfg   = BP_RST;
            addr_map = '0;
            for (int i = 0; i < 16; i++)
            begin
                rx_seen[i]      = 1'b0;
                latched_bits[i] = '0;
                quiet[i]        = 0;
                err_cnt[i]      = 0;
                comm[i]         = 1'b0;
                perm[i]         = 1'b0;
                missed[i]       = '0;
            end
            any_comm = 1'b0;
            any_perm = 1'b0;
            failures = 0;
        endfunction

        function void set_register(input logic [1:0] idx, input logic [63:0] v);
            case (idx)
                REG_CLR: clr_cfg  = v[CLR_W-1:0];
                REG_LIM: lim_cfg  = v[LIM_W-1:0];
                REG_BP:  bp_cfg   = v[BP_W-1:0];
                REG_MAP: addr_map = v;
                default: ;
            endcase
        endfunction

        // Board counts above the chain size saturate
        function int boards_in_use();
            return (bp_cfg > 16) ? 16 : int'(bp_cfg);
        endfunction

        function logic [3:0] chain_addr(input int i);
            return addr_map[4*(i & 15) +: 4];
        endfunction

        function result_t blank();
            result_t res;
            res = '0;
            res.any_comm_error = any_comm;
            res.any_perm_error = any_perm;
            return res;
        endfunction

        // Good/error counting for one board at end of cycle
        function void tally_board(input int i);
            if (rx_seen[i])
            begin
                if (quiet[i] >= clr_cfg)
                begin
                    quiet[i]   = clr_cfg;
                    err_cnt[i] = 0;
                    comm[i]    = 1'b0;
                end
            end
            else
            begin
                err_cnt[i] = err_cnt[i] + 1;
                quiet[i]   = 0;
                missed[i]  = missed[i] + 32'd1;
            end
            if (err_cnt[i] >= lim_cfg)
            begin
                err_cnt[i] = lim_cfg;
                comm[i]    = 1'b1;
                perm[i]    = 1'b1;
            end
            quiet[i] = (quiet[i] + 1) & 32'h7FF;
        endfunction

        function void predict_request(input request_t r);
            result_t     res;
            logic [31:0] w;
            logic [4:0]  addr;
            bit          ok;
            bit          any;
            int          n;
            n = boards_in_use();
            case (r.operation)
                OP_RX:
                begin
                    w = r.frame_word;
                    res = blank();
                    res.last = 1'b1;
                    ok = fold_nibbles(w) == 4'h0 && w[26:24] == RX_TYPE && w[3:0] == TRAILER;
                    if (ok)
                    begin
                        res.frame_ok   = 1'b1;
                        res.input_bits = w[23:8];
                        addr = w[31:27];
                        for (int i = 0; i < n; i++)
                        begin
                            if (!res.board_matched && addr < 16 && chain_addr(i) == addr[3:0])
                            begin
                                latched_bits[i]   = w[23:8];
                                rx_seen[i]        = 1'b1;
                                res.board_index   = 4'(i);
                                res.board_matched = 1'b1;
                            end
                        end
                    end
                    pending.push_back(res);
                end
                OP_TX:
                begin
                    w = {1'b0, chain_addr(r.board_select), TX_TYPE, r.output_bits, 4'h0, TRAILER};
                    w[7:4] = fold_nibbles(w);
                    res = blank();
                    res.board_index = r.board_select;
                    res.tx_frame    = w;
                    res.last        = 1'b1;
                    pending.push_back(res);
                end
                OP_EOC:
                begin
                    for (int i = 0; i < n; i++)
                        tally_board(i);
                    // reset request only honoured without a standing comm error
                    if (r.reset_request && !any_comm)
                    begin
                        any_perm = 1'b0;
                        for (int i = 0; i < n; i++)
                            perm[i] = 1'b0;
                    end
                    any = 1'b0;
                    for (int i = 0; i < n; i++)
                        any = any | comm[i];
                    any_comm = any;
                    if (any)
                        any_perm = 1'b1;
                    for (int i = 0; i < n; i++)
                    begin
                        if (any_perm)
                            latched_bits[i] = '0;
                        res = blank();
                        res.board_index      = 4'(i);
                        res.input_bits       = latched_bits[i];
                        res.board_comm_error = comm[i];
                        res.board_perm_error = perm[i];
                        res.invalid_count    = missed[i];
                        res.last             = (i == n - 1);
                        pending.push_back(res);
                    end
                    for (int i = 0; i < 16; i++)
                        rx_seen[i] = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void compare_field(input string name, input longint unsigned want,
                                    input longint unsigned got);
            if (want != got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $error("result with nothing pending: board_index %0d", got.board_index);
                failures++;
                return;
            end
            want = pending.pop_front();
            compare_field("board_index", want.board_index, got.board_index);
            compare_field("frame_ok", want.frame_ok, got.frame_ok);
            compare_field("board_matched", want.board_matched, got.board_matched);
            compare_field("input_bits", want.input_bits, got.input_bits);
            compare_field("board_comm_error", want.board_comm_error, got.board_comm_error);
            compare_field("board_perm_error", want.board_perm_error, got.board_perm_error);
            compare_field("invalid_count", want.invalid_count, got.invalid_count);
            compare_field("any_comm_error", want.any_comm_error, got.any_comm_error);
            compare_field("any_perm_error", want.any_perm_error, got.any_perm_error);
            compare_field("tx_frame", want.tx_frame, got.tx_frame);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [CFG_DW-1:0]   pwdata;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    rlsu_in_if  in_ch();
    rlsu_out_if out_ch();

    link_scoreboard sb;
    int unsigned    cycle_count = 0;
    int unsigned    requests_sent = 0;
    int unsigned    burst_left = 0;
    bit             hold_off_req = 1'b0;

    rs485_io_frame_link_supervisor_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.board_index      = out_ch.board_index;
            got.frame_ok         = out_ch.frame_ok;
            got.board_matched    = out_ch.board_matched;
            got.input_bits       = out_ch.input_bits;
            got.board_comm_error = out_ch.board_comm_error;
            got.board_perm_error = out_ch.board_perm_error;
            got.invalid_count    = out_ch.invalid_count;
            got.any_comm_error   = out_ch.any_comm_error;
            got.any_perm_error   = out_ch.any_perm_error;
            got.tx_frame         = out_ch.tx_frame;
            got.last             = out_ch.last;
            sb.check_result(got);
        end
    end

    // Result receiver: stall modes change at random, plus one long hold-off
    initial
    begin
        int unsigned mode;
        int unsigned mode_left;
        int unsigned tick;
        mode = 0;
        mode_left = 0;
        tick = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_off_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF - 1) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= $urandom_range(0, 1);
                    2: out_ch.ready <= (tick % 3 == 0);
                    default: out_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic logic [31:0] make_frame(input logic [4:0] addr, input logic [2:0] typ,
                                               input logic [15:0] bits, input logic [3:0] trailer);
        logic [31:0] w;
        w = {addr, typ, bits, 4'h0, trailer};
        w[7:4] = fold_nibbles(w);
        return w;
    endfunction

    function automatic request_t random_request(input logic [OP_W-1:0] op);
        request_t r;
        r.operation     = op;
        r.frame_word    = $urandom();
        r.board_select  = $urandom();
        r.output_bits   = $urandom();
        r.reset_request = $urandom();
        return r;
    endfunction

    function automatic request_t rx_request(input logic [31:0] frame);
        request_t r;
        r = random_request(OP_RX);
        r.frame_word = frame;
        return r;
    endfunction

    function automatic request_t tx_request(input logic [3:0] sel, input logic [15:0] bits);
        request_t r;
        r = random_request(OP_TX);
        r.board_select = sel;
        r.output_bits  = bits;
        return r;
    endfunction

    function automatic request_t eoc_request(input logic rr);
        request_t r;
        r = random_request(OP_EOC);
        r.reset_request = rr;
        return r;
    endfunction

    // Offer one request in bursts with random gaps; returns at the accepting edge
    task automatic send_item(input request_t r);
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= r.operation;
        in_ch.frame_word    <= r.frame_word;
        in_ch.board_select  <= r.board_select;
        in_ch.output_bits   <= r.output_bits;
        in_ch.reset_request <= r.reset_request;
        do @(posedge clk); while (!in_ch.ready);
        sb.predict_request(r);
        if (r.operation != OP_UNUSED)
            requests_sent++;
    endtask

    // Stop offering and wait for every pending result, then let the block go idle
    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, v);
    endtask

    task automatic configure(input logic [9:0] clr, input logic [7:0] lim,
                             input logic [4:0] bp, input logic [63:0] map);
        settle();
        write_reg(REG_CLR, 64'(clr));
        write_reg(REG_LIM, 64'(lim));
        write_reg(REG_BP, 64'(bp));
        write_reg(REG_MAP, map);
    endtask

    // Corrupted, unmatched or unrelated requests mixed into the refresh traffic
    task automatic send_noise();
        request_t    r;
        logic [31:0] w;
        logic [2:0]  typ;
        logic [3:0]  trl;
        w = make_frame($urandom(), RX_TYPE, $urandom(), TRAILER);
        case ($urandom_range(0, 9))
            0: r = rx_request($urandom());
            1: r = rx_request(w ^ (32'($urandom_range(1, 15)) << (4 * $urandom_range(0, 7))));
            2:
            begin
                do typ = $urandom(); while (typ == RX_TYPE);
                r = rx_request(make_frame($urandom(), typ, $urandom(), TRAILER));
            end
            3:
            begin
                do trl = $urandom(); while (trl == TRAILER);
                r = rx_request(make_frame($urandom(), RX_TYPE, $urandom(), trl));
            end
            4, 5: r = rx_request(w);
            9: r = random_request(OP_UNUSED);
            default: r = tx_request($urandom(), $urandom());
        endcase
        send_item(r);
    endtask

    // One refresh cycle: frames from most boards, some noise, then end of cycle
    task automatic run_refresh_cycle(input int miss_pct);
        int n;
        n = sb.boards_in_use();
        for (int b = 0; b < n; b++)
        begin
            if ($urandom_range(0, 99) < 12)
                send_noise();
            if ($urandom_range(0, 99) >= miss_pct)
                send_item(rx_request(make_frame({1'b0, sb.chain_addr(b)}, RX_TYPE,
                                                $urandom(), TRAILER)));
        end
        repeat ($urandom_range(0, 2)) send_noise();
        send_item(eoc_request($urandom_range(0, 3) == 0));
    endtask

    task automatic run_phase(input logic [9:0] clr, input logic [7:0] lim, input logic [4:0] bp,
                             input logic [63:0] map, input int quota, input int miss_pct,
                             input bit hold, input bit pause);
        int unsigned start;
        configure(clr, lim, bp, map);
        start = requests_sent;
        while (requests_sent - start < quota)
        begin
            if (hold && requests_sent - start >= quota / 4)
            begin
                hold_off_req = 1'b1;
                hold = 1'b0;
            end
            if (pause && requests_sent - start >= quota / 2)
            begin
                settle();
                pause = 1'b0;
            end
            run_refresh_cycle(miss_pct);
        end
    endtask

    initial
    begin
        logic [63:0] map;
        sb = new();
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.operation     <= OP_RX;
        in_ch.frame_word    <= '0;
        in_ch.board_select  <= '0;
        in_ch.output_bits   <= '0;
        in_ch.reset_request <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: one board at chain address 0
        send_item(rx_request(make_frame(5'd0, RX_TYPE, 16'hC3C3, TRAILER)));
        send_item(tx_request(4'd7, 16'h5AA5));
        send_item(eoc_request(1'b1));

        // Full chain, boards 0 and 1 share address 1, nobody at address 0
        configure(10'd1, 8'd2, 5'd16, 64'hFEDC_BA98_7654_3211);
        send_item(rx_request(make_frame(5'd1, RX_TYPE, 16'hFFFF, TRAILER)));
        send_item(rx_request(make_frame(5'd15, RX_TYPE, 16'h0000, TRAILER)));
        send_item(rx_request(make_frame(5'd16, RX_TYPE, 16'hA5A5, TRAILER)));
        send_item(rx_request(make_frame(5'd0, RX_TYPE, 16'h1234, TRAILER)));
        send_item(rx_request(make_frame(5'd31, RX_TYPE, 16'h5A5A, TRAILER) ^ 32'h0000_0010));
        send_item(rx_request(make_frame(5'd2, 3'd3, 16'h0F0F, TRAILER)));
        send_item(rx_request(make_frame(5'd3, RX_TYPE, 16'hF0F0, 4'hC)));
        send_item(rx_request(32'hFFFF_FFFF));
        send_item(rx_request(32'h0000_0000));
        send_item(tx_request(4'd0, 16'h0000));
        send_item(tx_request(4'd15, 16'hFFFF));
        send_item(random_request(OP_UNUSED));
        send_item(eoc_request(1'b0));
        send_item(eoc_request(1'b1));
        send_item(eoc_request(1'b0));
        send_item(eoc_request(1'b1));
        send_item(rx_request(make_frame(5'd1, RX_TYPE, 16'h8001, TRAILER)));
        send_item(eoc_request(1'b1));

        // Random refresh traffic under several register settings
        map = {$urandom(), $urandom()};
        map[7:4] = map[3:0];
        run_phase(10'd2, 8'd3, 5'd4, map, 80, 10, 1'b1, 1'b0);
        run_phase(10'd0, 8'd255, 5'd16, 64'hFEDC_BA98_7654_3210, 90, 15, 1'b0, 1'b1);
        run_phase(10'd1023, 8'd1, 5'd31, {$urandom(), $urandom()}, 80, 5, 1'b0, 1'b0);
        run_phase(10'd5, 8'd0, 5'd3, {$urandom(), $urandom()}, 70, 20, 1'b0, 1'b0);
        run_phase(10'd3, 8'd2, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF, 40, 10, 1'b0, 1'b0);
        run_phase(10'd1, 8'd4, 5'd7, {$urandom(), $urandom()}, 90, 25, 1'b0, 1'b0);

        settle();
        if (sb.failures == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
